// ===== design/mppr_pkg.sv =====
package mppr_pkg;

   // Width of the saturating error accumulator.
   localparam int SUM_WIDTH = 24;

   // Fixed field and datapath widths.
   localparam int POS_WIDTH = 8;
   localparam int ERR_WIDTH = POS_WIDTH + 1;
   localparam int GAIN_WIDTH = 16;
   localparam int SPEED_WIDTH = 8;
   localparam int BAND_WIDTH = 8;
   localparam int FRAC_BITS = 16;
   localparam int P_SHIFT = 8;

   // Signed product widths; gains are unsigned, so they get one extra zero bit.
   localparam int P_RAW_WIDTH = GAIN_WIDTH + 1 + ERR_WIDTH;
   localparam int P_TERM_WIDTH = P_RAW_WIDTH + P_SHIFT;
   localparam int I_TERM_WIDTH = GAIN_WIDTH + 1 + SUM_WIDTH;
   localparam int TOTAL_WIDTH =
      ((P_TERM_WIDTH > I_TERM_WIDTH) ? P_TERM_WIDTH : I_TERM_WIDTH) + 1;

   // Configuration port.
   localparam int PADDR_WIDTH = 4;
   localparam int PDATA_WIDTH = 32;

   typedef enum logic [1:0] {
      REG_KP          = 2'd0,
      REG_KI_T        = 2'd1,
      REG_SPEED_LIMIT = 2'd2,
      REG_DEAD_BAND   = 2'd3
   } reg_index_type;

   // Register reset values.
   localparam logic [GAIN_WIDTH-1:0] KP_RESET = 16'd256;
   localparam logic [GAIN_WIDTH-1:0] KI_T_RESET = 16'd983;
   localparam logic [SPEED_WIDTH-1:0] SPEED_LIMIT_RESET = 8'd100;
   localparam logic [BAND_WIDTH-1:0] DEAD_BAND_RESET = 8'd1;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] reference;
      logic signed [POS_WIDTH-1:0] position;
   } req_type;

   typedef struct packed {
      logic [SPEED_WIDTH-1:0] speed;
      logic                   direction;
      logic                   clamped;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_WIDTH-1:0]  kp;
      logic [GAIN_WIDTH-1:0]  ki_t;
      logic [SPEED_WIDTH-1:0] speed_limit;
      logic [BAND_WIDTH-1:0]  dead_band;
   } cfg_type;

   // Item passed from the error stage to the drive stage.
   typedef struct packed {
      logic signed [P_TERM_WIDTH-1:0] p_term;
      logic signed [I_TERM_WIDTH-1:0] i_term;
      logic                           direction;
   } term_type;

endpackage

// ===== design/mppr_csr.sv =====
module mppr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mppr_pkg::PADDR_WIDTH-1:0]    paddr,
   input  logic [mppr_pkg::PDATA_WIDTH-1:0]    pwdata,
   output logic [mppr_pkg::PDATA_WIDTH-1:0]    prdata,
   output logic                                pready,
   output mppr_pkg::cfg_type                   cfg
);

   mppr_pkg::cfg_type       cfg_ff;
   mppr_pkg::cfg_type       cfg_in;
   mppr_pkg::reg_index_type index;
   logic                    write_en;

   assign index = mppr_pkg::reg_index_type'(paddr[mppr_pkg::PADDR_WIDTH-1:2]);
   assign write_en = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   // Register write decode; upper data bits beyond each register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            mppr_pkg::REG_KP:          cfg_in.kp = pwdata[mppr_pkg::GAIN_WIDTH-1:0];
            mppr_pkg::REG_KI_T:        cfg_in.ki_t = pwdata[mppr_pkg::GAIN_WIDTH-1:0];
            mppr_pkg::REG_SPEED_LIMIT: cfg_in.speed_limit = pwdata[mppr_pkg::SPEED_WIDTH-1:0];
            mppr_pkg::REG_DEAD_BAND:   cfg_in.dead_band = pwdata[mppr_pkg::BAND_WIDTH-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp <= mppr_pkg::KP_RESET;
         cfg_ff.ki_t <= mppr_pkg::KI_T_RESET;
         cfg_ff.speed_limit <= mppr_pkg::SPEED_LIMIT_RESET;
         cfg_ff.dead_band <= mppr_pkg::DEAD_BAND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data mux.
   always_comb begin
      unique case (index)
         mppr_pkg::REG_KP:
            prdata = mppr_pkg::PDATA_WIDTH'(cfg_ff.kp);
         mppr_pkg::REG_KI_T:
            prdata = mppr_pkg::PDATA_WIDTH'(cfg_ff.ki_t);
         mppr_pkg::REG_SPEED_LIMIT:
            prdata = mppr_pkg::PDATA_WIDTH'(cfg_ff.speed_limit);
         mppr_pkg::REG_DEAD_BAND:
            prdata = mppr_pkg::PDATA_WIDTH'(cfg_ff.dead_band);
         default:
            prdata = '0;
      endcase
   end

endmodule

// ===== design/mppr_error_stage.sv =====
module mppr_error_stage (
   input  logic                clock,
   input  logic                reset,
   input  mppr_pkg::cfg_type   cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  mppr_pkg::req_type   in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output mppr_pkg::term_type  out_data
);

   localparam int S = mppr_pkg::SUM_WIDTH;
   localparam logic signed [S-1:0] SUM_MAX = {1'b0, {(S-1){1'b1}}};
   localparam logic signed [S-1:0] SUM_MIN = {1'b1, {(S-1){1'b0}}};

   logic                in_valid_ff;
   logic                in_valid_in;
   mppr_pkg::req_type   in_data_ff;
   mppr_pkg::req_type   in_data_in;
   logic                term_valid_ff;
   logic                term_valid_in;
   mppr_pkg::term_type  term_ff;
   mppr_pkg::term_type  term_in;
   logic signed [S-1:0] error_sum_ff;
   logic signed [S-1:0] error_sum_in;
   logic                last_dir_ff;
   logic                last_dir_in;
   logic                advance;

   logic signed [mppr_pkg::ERR_WIDTH-1:0]   err;
   logic signed [mppr_pkg::ERR_WIDTH-1:0]   neg_err;
   logic [mppr_pkg::BAND_WIDTH-1:0]         abs_err;
   logic signed [S:0]                       sum_wide;
   logic signed [S-1:0]                     sum_next;
   logic signed [mppr_pkg::P_RAW_WIDTH-1:0] p_raw;

   // The input register moves on whenever the term register is free or drains.
   assign advance = in_valid_ff && (!term_valid_ff || out_ready);
   assign in_ready = !in_valid_ff || advance;
   assign out_valid = term_valid_ff;
   assign out_data = term_ff;

   always_comb begin
      in_valid_in = in_ready ? in_valid : in_valid_ff;
      in_data_in = (in_valid && in_ready) ? in_data : in_data_ff;
      term_valid_in = advance || (term_valid_ff && !out_ready);
   end

   // Error, saturating accumulation (cleared when the error is zero), direction and both gain products.
   always_comb begin
      err = {in_data_ff.reference[mppr_pkg::POS_WIDTH-1], in_data_ff.reference}
          - {in_data_ff.position[mppr_pkg::POS_WIDTH-1], in_data_ff.position};
      neg_err = -err;
      abs_err = err[mppr_pkg::ERR_WIDTH-1] ? neg_err[mppr_pkg::BAND_WIDTH-1:0]
                                            : err[mppr_pkg::BAND_WIDTH-1:0];

      sum_wide = {error_sum_ff[S-1], error_sum_ff}
               + {{(S + 1 - mppr_pkg::ERR_WIDTH){err[mppr_pkg::ERR_WIDTH-1]}}, err};
      if (err == '0) begin
         sum_next = '0;
      end else if (sum_wide[S] != sum_wide[S-1]) begin
         sum_next = sum_wide[S] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_next = sum_wide[S-1:0];
      end

      // Outside the deadband the sign of the error picks the direction.
      if (abs_err > cfg.dead_band) begin
         last_dir_in = !err[mppr_pkg::ERR_WIDTH-1];
      end else begin
         last_dir_in = last_dir_ff;
      end

      p_raw = $signed({1'b0, cfg.kp}) * err;
      term_in.p_term = {p_raw, {mppr_pkg::P_SHIFT{1'b0}}};
      term_in.i_term = $signed({1'b0, cfg.ki_t}) * sum_next;
      term_in.direction = last_dir_in;

      error_sum_in = sum_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         term_valid_ff <= 1'b0;
         error_sum_ff <= '0;
         last_dir_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         term_valid_ff <= term_valid_in;
         if (advance) begin
            error_sum_ff <= error_sum_in;
            last_dir_ff <= last_dir_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      if (advance) begin
         term_ff <= term_in;
      end
   end

endmodule

// ===== design/mppr_drive_stage.sv =====
module mppr_drive_stage (
   input  logic                clock,
   input  logic                reset,
   input  mppr_pkg::cfg_type   cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  mppr_pkg::term_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output mppr_pkg::rsp_type   out_data
);

   localparam int T = mppr_pkg::TOTAL_WIDTH;
   localparam int F = mppr_pkg::FRAC_BITS;
   localparam int W = mppr_pkg::SPEED_WIDTH;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   mppr_pkg::rsp_type  rsp_ff;
   mppr_pkg::rsp_type  rsp_in;
   logic               load;

   logic signed [T-1:0] total;
   logic signed [T-1:0] neg_total;
   logic [T-1:0]        magnitude;
   logic                over_high;
   logic [W-1:0]        mag_low;

   assign in_ready = !rsp_valid_ff || out_ready;
   assign load = in_valid && in_ready;
   assign out_valid = rsp_valid_ff;
   assign out_data = rsp_ff;

   // Sum the two terms, take the magnitude in whole units and clamp it.
   always_comb begin
      total = T'(in_data.p_term) + T'(in_data.i_term);
      neg_total = -total;
      magnitude = total[T-1] ? neg_total : total;
      over_high = |magnitude[T-1:F+W];
      mag_low = magnitude[F+W-1:F];
      if (over_high || (mag_low > cfg.speed_limit)) begin
         rsp_in.speed = cfg.speed_limit;
         rsp_in.clamped = 1'b1;
      end else begin
         rsp_in.speed = mag_low;
         rsp_in.clamped = 1'b0;
      end
      rsp_in.direction = in_data.direction;
      rsp_valid_in = load || (rsp_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== design/motor_position_pi_regulator_unit.sv =====
// Channel    Direction  Signals                          Moves
// req        in         req_valid, req_ready, req_data   one control tick item
// rsp        out        rsp_valid, rsp_ready, rsp_data   one speed/direction item
// csr        in/out     psel, penable, pwrite, paddr,    gain and limit registers
//                       pwdata, prdata, pready
//
// An item passes three registers in turn: input, gain terms and result. One item
// is accepted per cycle unless a stall on rsp has filled all three registers.
// The error sum and held direction update as an item leaves the input register.
// Synchronous reset clears the sum, the direction and the registers to defaults.
// A stall on rsp fills the stages in turn; req_ready drops only when all are full.
module motor_position_pi_regulator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  mppr_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mppr_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mppr_pkg::PADDR_WIDTH-1:0]  paddr,
   input  logic [mppr_pkg::PDATA_WIDTH-1:0]  pwdata,
   output logic [mppr_pkg::PDATA_WIDTH-1:0]  prdata,
   output logic                              pready
);

   mppr_pkg::cfg_type  cfg;
   mppr_pkg::term_type term;
   logic               term_valid;
   logic               term_ready;

   // Configuration registers.
   mppr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Error, accumulator and gain products.
   mppr_error_stage u_error_stage (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (term_valid),
      .out_ready (term_ready),
      .out_data  (term)
   );

   // Magnitude, clamp and result register.
   mppr_drive_stage u_drive_stage (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (term_valid),
      .in_ready  (term_ready),
      .in_data   (term),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule
